/* rtl/dtti_pkg.sv */
// ---------------------------------------------------------------------------
// dtti_pkg
// Types and constants shared by the decimal text to int64 parser.
// ---------------------------------------------------------------------------
package dtti_pkg;

  localparam int unsigned ACC_W = 64;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // parse state of the text in progress
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             neg;
    logic             at_first;
    logic             seen;
    logic             failed;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    acc:      '0,
    neg:      1'b0,
    at_first: 1'b1,
    seen:     1'b0,
    failed:   1'b0
  };

  // finished text waiting for sign application
  typedef struct packed {
    logic [ACC_W-1:0] mag;
    logic             neg;
    logic             ok;
  } parse_result_t;

endpackage

/* rtl/dtti_step.sv */
// ---------------------------------------------------------------------------
// dtti_step
// One byte of parse update: sign, digit accumulate with overflow check.
// ---------------------------------------------------------------------------
module dtti_step (
  input  dtti_pkg::parse_state_t cur,
  input  logic [7:0]             text_byte,
  input  logic                   no_byte,
  output dtti_pkg::parse_state_t nxt
);

  logic                        is_sign;
  logic                        is_digit;
  logic [dtti_pkg::ACC_W+3:0]  wide;
  logic [dtti_pkg::ACC_W+3:0]  sum;
  logic                        ovf;

  assign is_sign  = (text_byte == dtti_pkg::CHAR_PLUS) || (text_byte == dtti_pkg::CHAR_MINUS);
  assign is_digit = (text_byte >= dtti_pkg::CHAR_ZERO) && (text_byte <= dtti_pkg::CHAR_NINE);

  // acc * 10 + digit; overflow when anything lands above bit 63
  assign wide = {4'b0, cur.acc};
  assign sum  = (wide << 3) + (wide << 1) + {{dtti_pkg::ACC_W{1'b0}}, text_byte[3:0]};
  assign ovf  = |sum[dtti_pkg::ACC_W+3:dtti_pkg::ACC_W];

  always_comb begin
    nxt = cur;
    if (!no_byte) begin
      nxt.at_first = 1'b0;
      if (!cur.failed) begin
        if (cur.at_first && is_sign) begin
          nxt.neg = (text_byte == dtti_pkg::CHAR_MINUS);
        end else if (!is_digit || ovf) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.acc  = sum[dtti_pkg::ACC_W-1:0];
          nxt.seen = 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/decimal_text_to_int64.sv */
// ---------------------------------------------------------------------------
// decimal_text_to_int64
// Streams decimal ASCII text and returns the signed 64-bit value with a
// pass/reject flag on the last byte of each text.
// ---------------------------------------------------------------------------
// channel | dir | tdata            | tuser          | tlast
// s_*     | in  | text_byte[7:0]   | no_byte        | end_of_text
// m_*     | out | value[63:0]      | accepted       | -
//
// one input item per cycle while s_tready is high; parse state updates in the cycle of acceptance
// a result leaves through a result stage after its last item, then the
// output register that applies the sign
// s_tready drops only while both result stages hold items and m_tready is low
// rst clears parse state and both result stages; payload registers are not reset
// ---------------------------------------------------------------------------
module decimal_text_to_int64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] no_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] value
  output logic        m_tuser    // [0] accepted
);

  dtti_pkg::parse_state_t  st;
  dtti_pkg::parse_state_t  st_step;
  dtti_pkg::parse_result_t res_next;
  dtti_pkg::parse_result_t res;
  logic                    res_valid;
  logic                    take;
  logic                    take_last;
  logic                    out_adv;
  logic                    in_range;

  dtti_step u_step (
    .cur       (st),
    .text_byte (s_tdata),
    .no_byte   (s_tuser),
    .nxt       (st_step)
  );

  assign out_adv   = !m_tvalid || m_tready;
  assign s_tready  = !res_valid || out_adv;
  assign take      = s_tvalid && s_tready;
  assign take_last = take && s_tlast;

  // -2^63 allowed only with a leading minus
  assign in_range = !st_step.acc[63] || (st_step.neg && (st_step.acc[62:0] == '0));

  always_comb begin
    res_next.mag = st_step.acc;
    res_next.neg = st_step.neg;
    res_next.ok  = !st_step.failed && st_step.seen && in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= dtti_pkg::PARSE_CLEAR;
    end else if (take_last) begin
      st <= dtti_pkg::PARSE_CLEAR;
    end else if (take) begin
      st <= st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take_last) begin
      res_valid <= 1'b1;
    end else if (out_adv) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && res_valid) begin
      if (!res.ok) begin
        m_tdata <= '0;
      end else if (res.neg) begin
        m_tdata <= '0 - res.mag;
      end else begin
        m_tdata <= res.mag;
      end
      m_tuser <= res.ok;
    end
  end

`ifndef SYNTH
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("rejected item carries nonzero value");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take_last |=> st.at_first && !st.failed && !st.seen && st.acc == '0)
    else $error("parse state not cleared after last item");

  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    st.failed && !take_last |=> st.failed)
    else $error("error flag dropped mid-text");

  a_seen_not_first: assert property (@(posedge clk) disable iff (rst)
    st.seen |-> !st.at_first)
    else $error("digit seen while still at first byte");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_adv |-> !s_tready)
    else $error("input taken while result stages are full");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for decimal_text_to_int64
// Streams short decimal texts, well formed and broken, into the parser under
// several mixes of sender gaps and receiver stalls. A cycle-free model of the
// parse state predicts each result; the value and the accept flag of every
// result are compared in order.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [dtti_pkg::ACC_W-1:0] value;
    logic                       accepted;
  } int_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;    // [0] no_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [63:0] value
  logic        m_tuser;           // [0] accepted

  decimal_text_to_int64 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the parse state
  logic [dtti_pkg::ACC_W-1:0] mag_acc = '0;
  logic                       sign_neg = 1'b0;
  logic                       first_pending = 1'b1;
  logic                       digit_seen = 1'b0;
  logic                       text_failed = 1'b0;

  int_result_t parsed_q[$];
  logic [7:0]  text_buf[$];
  int_result_t want;
  int          errors = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          gap_pct = 0;

  // fold one accepted item into the model, queue a result on the last one
  function automatic void parse_text_item(logic [7:0] b, logic last, logic nb);
    logic                       first;
    logic [dtti_pkg::ACC_W-1:0] d;
    logic [dtti_pkg::ACC_W-1:0] limit;
    logic                       ok;
    int_result_t                r;
    if (!nb) begin
      first = first_pending;
      first_pending = 1'b0;
      if (!text_failed) begin
        if (first && (b == dtti_pkg::CHAR_PLUS || b == dtti_pkg::CHAR_MINUS)) begin
          sign_neg = (b == dtti_pkg::CHAR_MINUS);
        end else if (b < dtti_pkg::CHAR_ZERO || b > dtti_pkg::CHAR_NINE) begin
          text_failed = 1'b1;
        end else begin
          d = dtti_pkg::ACC_W'(b - dtti_pkg::CHAR_ZERO);
          // would the next step pass 2^64 - 1
          if (mag_acc > ({dtti_pkg::ACC_W{1'b1}} - d) / 10) begin
            text_failed = 1'b1;
          end else begin
            mag_acc = mag_acc * 10 + d;
            digit_seen = 1'b1;
          end
        end
      end
    end
    if (last) begin
      limit = sign_neg ? {1'b1, {(dtti_pkg::ACC_W-1){1'b0}}}
                       : {1'b0, {(dtti_pkg::ACC_W-1){1'b1}}};
      ok = !text_failed && digit_seen && mag_acc <= limit;
      r.value = ok ? (sign_neg ? -mag_acc : mag_acc) : '0;
      r.accepted = ok;
      parsed_q.push_back(r);
      mag_acc = '0;
      sign_neg = 1'b0;
      first_pending = 1'b1;
      digit_seen = 1'b0;
      text_failed = 1'b0;
    end
  endfunction

  always @(negedge clk) begin
    m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result: value %0d accepted %0b", $signed(m_tdata), m_tuser);
        errors++;
      end else begin
        want = parsed_q.pop_front();
        if (m_tdata !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), $signed(m_tdata));
          errors++;
        end
        if (m_tuser !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last, input logic nb);
    @(negedge clk);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= nb;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_text_item(b, last, nb);
    if (!nb || last) items_sent++;
  endtask

  // send text_buf; the last byte carries tlast unless an empty end item follows
  task automatic send_text(input bit empty_end);
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      send_item(text_buf[i], (i == n - 1) && !empty_end, 1'b0);
    end
    if (n == 0 || empty_end) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic build_random_text();
    int                         kind;
    int                         pos;
    logic [dtti_pkg::ACC_W-1:0] mag;
    string                      digits;
    kind = $urandom_range(99);
    text_buf.delete();
    if (kind >= 85) begin
      // noise
      repeat ($urandom_range(6)) text_buf.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(6))
        0: mag = dtti_pkg::ACC_W'($urandom_range(9));
        1: mag = dtti_pkg::ACC_W'($urandom);
        2: mag = {$urandom, $urandom};
        3: mag = {1'b1, {(dtti_pkg::ACC_W-1){1'b0}}} - 3 +
                 dtti_pkg::ACC_W'($urandom_range(5));
        4: mag = {dtti_pkg::ACC_W{1'b1}} - dtti_pkg::ACC_W'($urandom_range(3));
        5: mag = {$urandom, $urandom} >> $urandom_range(63);
        default: mag = {dtti_pkg::ACC_W{1'b1}} / 10;
      endcase
      digits = $sformatf("%0d", mag);
      // one more digit can push past the top or land right at it
      if ($urandom_range(5) == 0)
        digits = {digits, string'(8'(dtti_pkg::CHAR_ZERO + $urandom_range(9)))};
      if ($urandom_range(7) == 0) digits = {"0", digits};
      case ($urandom_range(2))
        1: text_buf.push_back(dtti_pkg::CHAR_MINUS);
        2: text_buf.push_back(dtti_pkg::CHAR_PLUS);
        default: ;
      endcase
      for (int i = 0; i < digits.len(); i++) text_buf.push_back(digits[i]);
      if (kind >= 70) begin
        pos = $urandom_range(text_buf.size() - 1);
        if ($urandom_range(1) == 0 || text_buf.size() < 2)
          text_buf[pos] = 8'($urandom_range(255));
        else
          text_buf[$urandom_range(text_buf.size() - 1, 1)] =
            $urandom_range(1) ? dtti_pkg::CHAR_PLUS : dtti_pkg::CHAR_MINUS;
      end
    end
  endtask

  task automatic test_accepted_forms();
    load_text("0");
    send_text(1'b0);
    load_text("-7");
    send_text(1'b0);
    // empty item in the middle of a text changes nothing
    send_item(dtti_pkg::CHAR_PLUS, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item("4", 1'b0, 1'b0);
    send_item("2", 1'b1, 1'b0);
    load_text("9");
    send_text(1'b1);
    load_text("-0");
    send_text(1'b0);
  endtask

  task automatic test_rejected_forms();
    load_text("");
    send_text(1'b0);
    load_text("+");
    send_text(1'b0);
    load_text("-");
    send_text(1'b1);
    load_text("1-");
    send_text(1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    // bytes after a failure are ignored
    load_text("a5");
    send_text(1'b0);
    send_item(dtti_pkg::CHAR_ZERO - 8'd1, 1'b1, 1'b0);
    send_item(dtti_pkg::CHAR_NINE + 8'd1, 1'b1, 1'b0);
  endtask

  task automatic test_random_texts(input int send_pct, input int stall_pct, input int n_items);
    int  target;
    bit  burst;
    target = items_sent + n_items;
    gap_pct = 5;
    while (items_sent < target) begin
      burst = ($urandom_range(5) == 0);
      send_idle  = burst ? 0 : send_pct;
      recv_stall = burst ? 0 : stall_pct;
      build_random_text();
      send_text($urandom_range(6) == 0);
    end
    send_idle = 0;
    gap_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_accepted_forms();
    test_rejected_forms();
    drain_results();
    test_random_texts(0, 0, 500);
    drain_results();
    test_random_texts(45, 0, 500);
    test_random_texts(0, 45, 500);
    drain_results();
    test_random_texts(11, 11, 500);
    drain_results();
    recv_stall = 0;
    repeat (8) @(posedge clk);
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dtti_pkg.sv
rtl/dtti_step.sv
rtl/decimal_text_to_int64.sv
dv/testbench.sv
